[rtl/tcdq_pkg.sv]
`default_nettype none
package tcdq_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned KEY_W     = 32;
  localparam int unsigned BYTES_W   = 48;
  localparam int unsigned SIZE_W    = 10;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned CFG_W     = 48;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLED       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIG_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_SIZE  = 2'd2;

  localparam logic               RST_ENABLED       = 1'b1;
  localparam logic [BYTES_W-1:0] RST_BIG_THRESHOLD = 48'd1048576;
  localparam logic [SIZE_W-1:0]  RST_DEFAULT_SIZE  = 10'd128;

  localparam logic KIND_ENQ = 1'b0;
  localparam logic KIND_DEQ = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_REJECTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_QUEUED    = 3'd2,
    ST_POPPED    = 3'd3,
    ST_EMPTY     = 3'd4
  } status_e;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0] cnt_t;

  localparam ptr_t PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam cnt_t CNT_FULL = CNT_W'(QUEUE_DEPTH);

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [BYTES_W-1:0] bytes;
    logic [SIZE_W-1:0]  size;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic               kind;
    logic [KEY_W-1:0]   key;
    logic [BYTES_W-1:0] bytes;
    logic [SIZE_W-1:0]  size;
  } req_t;

  typedef struct packed {
    logic               enabled;
    logic [BYTES_W-1:0] big_threshold;
    logic [SIZE_W-1:0]  default_size;
  } cfg_t;

  typedef struct packed {
    status_e            status;
    logic [KEY_W-1:0]   key;
    logic [BYTES_W-1:0] bytes;
    logic [SIZE_W-1:0]  size;
    logic               from_big;
  } res_t;

  typedef struct packed {
    logic   we;
    ptr_t   waddr;
    entry_t wdata;
  } ram_wr_t;

  function automatic ptr_t ptr_inc(ptr_t p);
    ptr_inc = (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

endpackage
`default_nettype wire

[rtl/tcdq_ram.sv]
`default_nettype none
module tcdq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

[rtl/tcdq_ctrl.sv]
`default_nettype none
module tcdq_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  tcdq_pkg::req_t   req_i,
  input  tcdq_pkg::cfg_t   cfg_i,
  input  logic             out_free_i,
  output logic             res_valid_o,
  output tcdq_pkg::res_t   res_o,
  output tcdq_pkg::ptr_t   rd_addr_o,
  output tcdq_pkg::ram_wr_t s_wr_o,
  output tcdq_pkg::ram_wr_t b_wr_o,
  input  tcdq_pkg::entry_t s_rdata_i,
  input  tcdq_pkg::entry_t b_rdata_i
);
  import tcdq_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SCAN     = 3'd1;
  localparam logic [2:0] S_DECIDE   = 3'd2;
  localparam logic [2:0] S_POP_RD   = 3'd3;
  localparam logic [2:0] S_POP_DATA = 3'd4;
  localparam logic [2:0] S_FINISH   = 3'd5;

  logic [2:0] state_q, state_d;
  req_t       req_q, req_d;
  res_t       res_q, res_d;
  ptr_t       s_head_q, s_head_d, b_head_q, b_head_d;
  cnt_t       s_cnt_q, s_cnt_d, b_cnt_q, b_cnt_d;
  ptr_t       scan_ptr_q, scan_ptr_d;
  cnt_t       issue_q, issue_d;
  logic       sel_q, sel_d;
  logic       pop_sel_q, pop_sel_d;
  logic       cmp_vld_q, cmp_vld_d;
  logic       cmp_sel_q, cmp_sel_d;

  logic             issuing;
  logic             hit;
  logic [KEY_W-1:0] rd_key;
  logic             cls;
  ptr_t             cls_head;
  cnt_t             cls_cnt;
  logic [CNT_W:0]   tail_sum;
  ptr_t             tail;
  entry_t           new_entry;
  entry_t           pop_entry;

  assign issuing  = issue_q != (sel_q ? b_cnt_q : s_cnt_q);
  assign rd_key   = cmp_sel_q ? b_rdata_i.key : s_rdata_i.key;
  assign hit      = cmp_vld_q && (rd_key == req_q.key);

  assign cls      = req_q.bytes >= cfg_i.big_threshold;
  assign cls_head = cls ? b_head_q : s_head_q;
  assign cls_cnt  = cls ? b_cnt_q : s_cnt_q;

  always_comb begin
    tail_sum = (CNT_W+1)'(cls_head) + (CNT_W+1)'(cls_cnt);
    if (tail_sum >= (CNT_W+1)'(QUEUE_DEPTH)) begin
      tail_sum = tail_sum - (CNT_W+1)'(QUEUE_DEPTH);
    end
    tail = tail_sum[PTR_W-1:0];
  end

  assign new_entry.key   = req_q.key;
  assign new_entry.bytes = req_q.bytes;
  assign new_entry.size  = (req_q.size != '0) ? req_q.size : cfg_i.default_size;
  assign pop_entry       = pop_sel_q ? b_rdata_i : s_rdata_i;

  always_comb begin
    state_d    = state_q;
    req_d      = req_q;
    res_d      = res_q;
    s_head_d   = s_head_q;
    b_head_d   = b_head_q;
    s_cnt_d    = s_cnt_q;
    b_cnt_d    = b_cnt_q;
    scan_ptr_d = scan_ptr_q;
    issue_d    = issue_q;
    sel_d      = sel_q;
    pop_sel_d  = pop_sel_q;
    cmp_vld_d  = 1'b0;
    cmp_sel_d  = sel_q;
    rd_addr_o  = scan_ptr_q;
    s_wr_o     = '{we: 1'b0, waddr: tail, wdata: new_entry};
    b_wr_o     = '{we: 1'b0, waddr: tail, wdata: new_entry};
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          req_d = req_i;
          res_d = '0;
          if (req_i.kind == KIND_DEQ) begin
            state_d = S_POP_RD;
          end else if (!cfg_i.enabled) begin
            res_d.status = ST_REJECTED;
            state_d      = S_FINISH;
          end else begin
            sel_d      = 1'b0;
            scan_ptr_d = s_head_q;
            issue_d    = '0;
            state_d    = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          res_d.status = ST_DUPLICATE;
          state_d      = S_FINISH;
        end else if (issuing) begin
          cmp_vld_d  = 1'b1;
          scan_ptr_d = ptr_inc(scan_ptr_q);
          issue_d    = issue_q + 1'b1;
        end else if (!cmp_vld_q) begin
          if (!sel_q) begin
            sel_d      = 1'b1;
            scan_ptr_d = b_head_q;
            issue_d    = '0;
          end else begin
            state_d = S_DECIDE;
          end
        end
      end
      S_DECIDE: begin
        if (cls_cnt == CNT_FULL) begin
          res_d.status = ST_REJECTED;
        end else begin
          res_d.status = ST_QUEUED;
          if (cls) begin
            b_wr_o.we = 1'b1;
            b_cnt_d   = b_cnt_q + 1'b1;
          end else begin
            s_wr_o.we = 1'b1;
            s_cnt_d   = s_cnt_q + 1'b1;
          end
        end
        state_d = S_FINISH;
      end
      S_POP_RD: begin
        if (s_cnt_q != '0) begin
          rd_addr_o = s_head_q;
          pop_sel_d = 1'b0;
          state_d   = S_POP_DATA;
        end else if (b_cnt_q != '0) begin
          rd_addr_o = b_head_q;
          pop_sel_d = 1'b1;
          state_d   = S_POP_DATA;
        end else begin
          res_d.status = ST_EMPTY;
          state_d      = S_FINISH;
        end
      end
      S_POP_DATA: begin
        res_d.status   = ST_POPPED;
        res_d.key      = pop_entry.key;
        res_d.bytes    = pop_entry.bytes;
        res_d.size     = pop_entry.size;
        res_d.from_big = pop_sel_q;
        if (pop_sel_q) begin
          b_head_d = ptr_inc(b_head_q);
          b_cnt_d  = b_cnt_q - 1'b1;
        end else begin
          s_head_d = ptr_inc(s_head_q);
          s_cnt_d  = s_cnt_q - 1'b1;
        end
        state_d = S_FINISH;
      end
      S_FINISH: begin
        if (out_free_i) begin
          res_valid_o = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign res_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      s_head_q   <= '0;
      b_head_q   <= '0;
      s_cnt_q    <= '0;
      b_cnt_q    <= '0;
      scan_ptr_q <= '0;
      issue_q    <= '0;
      sel_q      <= 1'b0;
      pop_sel_q  <= 1'b0;
      cmp_vld_q  <= 1'b0;
      cmp_sel_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      s_head_q   <= s_head_d;
      b_head_q   <= b_head_d;
      s_cnt_q    <= s_cnt_d;
      b_cnt_q    <= b_cnt_d;
      scan_ptr_q <= scan_ptr_d;
      issue_q    <= issue_d;
      sel_q      <= sel_d;
      pop_sel_q  <= pop_sel_d;
      cmp_vld_q  <= cmp_vld_d;
      cmp_sel_q  <= cmp_sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    res_q <= res_d;
  end

endmodule
`default_nettype wire

[rtl/two_class_dedup_job_queue.sv]
// Enqueue: the key scan runs one entry a cycle through a single comparator.
// One item at a time; a finished result waits in the output register while the
// next item is taken. Reset clears fill counts, pointers and output valid and loads
// the register defaults; queue storage is not cleared.
`default_nettype none
module two_class_dedup_job_queue (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               kind_i,
  input  logic [tcdq_pkg::KEY_W-1:0]         job_key_i,
  input  logic [tcdq_pkg::BYTES_W-1:0]       job_bytes_i,
  input  logic [tcdq_pkg::SIZE_W-1:0]        job_size_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [tcdq_pkg::STATUS_W-1:0]      status_o,
  output logic [tcdq_pkg::KEY_W-1:0]         out_key_o,
  output logic [tcdq_pkg::BYTES_W-1:0]       out_bytes_o,
  output logic [tcdq_pkg::SIZE_W-1:0]        out_size_o,
  output logic                               from_big_o,
  input  logic                               cfg_we_i,
  input  logic [tcdq_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [tcdq_pkg::CFG_W-1:0]         cfg_data_i
);
  import tcdq_pkg::*;

  cfg_t    cfg_q;
  req_t    req;
  res_t    res;
  res_t    out_q;
  logic    out_valid_q;
  logic    out_free;
  logic    res_valid;
  ptr_t    rd_addr;
  ram_wr_t s_wr;
  ram_wr_t b_wr;
  entry_t  s_rdata;
  entry_t  b_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enabled       <= RST_ENABLED;
      cfg_q.big_threshold <= RST_BIG_THRESHOLD;
      cfg_q.default_size  <= RST_DEFAULT_SIZE;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ENABLED:       cfg_q.enabled       <= cfg_data_i[0];
        CFG_BIG_THRESHOLD: cfg_q.big_threshold <= cfg_data_i[BYTES_W-1:0];
        CFG_DEFAULT_SIZE:  cfg_q.default_size  <= cfg_data_i[SIZE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign req.kind  = kind_i;
  assign req.key   = job_key_i;
  assign req.bytes = job_bytes_i;
  assign req.size  = job_size_i;

  tcdq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_i       (req),
    .cfg_i       (cfg_q),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_o       (res),
    .rd_addr_o   (rd_addr),
    .s_wr_o      (s_wr),
    .b_wr_o      (b_wr),
    .s_rdata_i   (s_rdata),
    .b_rdata_i   (b_rdata)
  );

  tcdq_ram #(
    .Width (ENTRY_W),
    .Depth (QUEUE_DEPTH)
  ) u_small_ram (
    .clk_i   (clk_i),
    .we_i    (s_wr.we),
    .waddr_i (s_wr.waddr),
    .wdata_i (s_wr.wdata),
    .raddr_i (rd_addr),
    .rdata_o (s_rdata)
  );

  tcdq_ram #(
    .Width (ENTRY_W),
    .Depth (QUEUE_DEPTH)
  ) u_big_ram (
    .clk_i   (clk_i),
    .we_i    (b_wr.we),
    .waddr_i (b_wr.waddr),
    .wdata_i (b_wr.wdata),
    .raddr_i (rd_addr),
    .rdata_o (b_rdata)
  );

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_q.status;
  assign out_key_o   = out_q.key;
  assign out_bytes_o = out_q.bytes;
  assign out_size_o  = out_q.size;
  assign from_big_o  = out_q.from_big;

endmodule
`default_nettype wire

[rtl/tcdq_checker.sv]
`default_nettype none
module tcdq_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic                               in_ready_o,
  input  logic                               out_valid_o,
  input  logic                               out_ready_i,
  input  logic [tcdq_pkg::STATUS_W-1:0]      status_o,
  input  logic [tcdq_pkg::KEY_W-1:0]         out_key_o,
  input  logic [tcdq_pkg::BYTES_W-1:0]       out_bytes_o,
  input  logic [tcdq_pkg::SIZE_W-1:0]        out_size_o,
  input  logic                               from_big_o
);
  import tcdq_pkg::*;

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_o;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o)
    else $error("ready held after an accepted item");

  a_fields_zero_unless_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_POPPED) |->
      (out_key_o == '0) && (out_bytes_o == '0) && (out_size_o == '0) && !from_big_o)
    else $error("payload not cleared on a non-pop result");

  a_result_follows_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result appeared without an item in flight");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
      $stable(out_key_o) && $stable(from_big_o))
    else $error("stalled result changed");

endmodule

bind two_class_dedup_job_queue tcdq_checker u_tcdq_checker (.*);
`default_nettype wire
